### sv/aes_cbc_pkg.sv
// shared tables and round functions for the block cipher core
package aes_cbc_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] blk_type;

   localparam int NUM_ENTRIES = 30;
   localparam int ENTRY_AW = 5;

   localparam logic [1:0] MODE_CBC_ENC = 2'd0;
   localparam logic [1:0] MODE_CBC_DEC = 2'd1;
   localparam logic [1:0] MODE_ECB_ENC = 2'd2;
   localparam logic [1:0] MODE_ECB_DEC = 2'd3;

   localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
   localparam logic [2:0] REG_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] REG_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] REG_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] REG_KEY_WORD_3 = 3'd4;
   localparam logic [2:0] REG_CIPHER_MODE = 3'd5;

   localparam byte_type SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic byte_type xtime(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // inverse of the affine step of the s-box
   function automatic byte_type aff_inv(input byte_type y);
      return {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]} ^ 8'h05;
   endfunction

   // gf inverse is aff_inv(sbox(x)), so the inverse s-box follows from the forward one
   function automatic byte_type inv_sbox(input byte_type y);
      return aff_inv(SBOX[aff_inv(y)]);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // forward round without the key add; byte 0 sits in the top bits
   function automatic blk_type fwd_round(input blk_type s, input logic last_rnd);
      byte_type sb [16];
      byte_type sh [16];
      blk_type o;
      byte_type a0, a1, a2, a3;
      for (int i = 0; i < 16; i++) sb[i] = SBOX[s[127-8*i -: 8]];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) sh[r+4*c] = sb[r+4*((c+r)%4)];
      for (int c = 0; c < 4; c++) begin
         a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
         if (last_rnd) begin
            o[127-32*c -: 32] = {a0, a1, a2, a3};
         end else begin
            o[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                 a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                 a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                 xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
         end
      end
      return o;
   endfunction

   function automatic blk_type inv_shift_sub(input blk_type s);
      byte_type sh [16];
      blk_type o;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) sh[r+4*((c+r)%4)] = s[127-8*(r+4*c) -: 8];
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = inv_sbox(sh[i]);
      return o;
   endfunction

   function automatic blk_type inv_mix(input blk_type s);
      blk_type o;
      byte_type a [4];
      byte_type x2 [4];
      byte_type x4 [4];
      byte_type x8 [4];
      byte_type m9 [4];
      byte_type m11 [4];
      byte_type m13 [4];
      byte_type m14 [4];
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            a[j] = s[127-8*(4*c+j) -: 8];
            x2[j] = xtime(a[j]);
            x4[j] = xtime(x2[j]);
            x8[j] = xtime(x4[j]);
            m9[j] = x8[j] ^ a[j];
            m11[j] = x8[j] ^ x2[j] ^ a[j];
            m13[j] = x8[j] ^ x4[j] ^ a[j];
            m14[j] = x8[j] ^ x4[j] ^ x2[j];
         end
         o[127-32*c -: 32] = {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
      end
      return o;
   endfunction

endpackage

### sv/aes_cbc_ecb_cipher_core.sv
// block cipher core: key schedule sequencer, round key memory and one shared round unit
//
//   channel  direction  contents
//   req_     in         tdata {block_low, block_high}, tuser first_block
//   rsp_     out        tdata {result_low, result_high}, tuser mode_error
//   csr_     in         write enable, register index, 64-bit data
//
// a block passes from transfer to result through one round key memory read, nr + 1 passes
// through the round unit and one output load; an unsupported mode goes from the transfer
// straight to the done state, skipping the key read and the round unit.
// after reset and after any key register write the schedule is rebuilt, 4 * nr + 4 words,
// one schedule word a cycle unless a key write restarts it; req_tready stays low meanwhile.
// a result that is not taken holds the core until rsp_tready rises.
module aes_cbc_ecb_cipher_core
   import aes_cbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_high, block_low
   input  logic         req_tuser,   // first_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_high, result_low
   output logic         rsp_tuser,   // mode_error
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   key_length_ff;
   logic [63:0]  key_word_ff [4];
   logic [1:0]   cipher_mode_ff;
   logic         stale_ff, stale_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] din_ff, din_in;
   logic [1:0]   mode_ff, mode_in;
   logic [3:0]   step_ff, step_in;
   logic [3:0]   nr_ff, nr_in;
   logic [3:0]   nk_ff, nk_in;
   logic [5:0]   wi_ff, wi_in;
   logic [2:0]   kc_ff, kc_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  win_ff [8];
   logic [63:0]  rk_hi_ff, rk_lo_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic         rsp_err_ff, rsp_err_in;
   logic [63:0]  rk_mem [NUM_ENTRIES];

   logic         key_wr, req_xfer, start_exp, shift_win, mem_we, rd_en, out_free;
   logic [1:0]   len_sat;
   logic [3:0]   rd_step, rd_rnd;
   logic [5:0]   last_wi;
   logic [31:0]  tw, new_word, old_word, key_half;
   logic [63:0]  kw_sel;
   logic [127:0] rk, enc_out, dec_mid, dec_out, step_out, fin;
   logic         last_step, is_dec;

   assign key_wr   = csr_we && (csr_addr == REG_KEY_LENGTH || csr_addr == REG_KEY_WORD_0 ||
                     csr_addr == REG_KEY_WORD_1 || csr_addr == REG_KEY_WORD_2 ||
                     csr_addr == REG_KEY_WORD_3);
   assign req_tready = (state_ff == ST_IDLE) && !stale_ff;
   assign req_xfer = req_tvalid && req_tready;
   assign start_exp = (state_ff == ST_IDLE) && stale_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign len_sat  = (key_length_ff == 2'd3) ? 2'd2 : key_length_ff;
   assign last_wi  = {nr_ff, 2'b11};

   // key schedule word for the current index
   assign kw_sel   = key_word_ff[wi_ff[2:1]];
   assign key_half = wi_ff[0] ? kw_sel[31:0] : kw_sel[63:32];
   always_comb begin
      old_word = win_ff[7];
      unique case (nk_ff)
         4'd4:    old_word = win_ff[3];
         4'd6:    old_word = win_ff[5];
         default: old_word = win_ff[7];
      endcase
      tw = win_ff[0];
      if (kc_ff == 3'd0) begin
         tw = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk_ff == 4'd8 && kc_ff == 3'd4) begin
         tw = sub_word(win_ff[0]);
      end
      new_word = ({2'b00, wi_ff} < {2'b00, nk_ff, 2'b00} >> 2) ? key_half : (old_word ^ tw);
   end
   assign shift_win = (state_ff == ST_EXPAND) && !key_wr;
   assign mem_we    = shift_win && wi_ff[0];

   // shared round unit
   assign is_dec    = (mode_ff == MODE_CBC_DEC);
   assign rk        = {rk_hi_ff, rk_lo_ff};
   assign last_step = (step_ff == nr_ff);
   assign enc_out   = fwd_round(blk_ff, last_step) ^ rk;
   assign dec_mid   = inv_shift_sub(blk_ff) ^ rk;
   assign dec_out   = last_step ? dec_mid : inv_mix(dec_mid);
   assign step_out  = (step_ff == 4'd0) ? (blk_ff ^ rk) : (is_dec ? dec_out : enc_out);
   assign fin       = is_dec ? (blk_ff ^ chain_ff) : blk_ff;

   // key memory read for the next step
   assign rd_step = (state_ff == ST_FETCH) ? 4'd0 : (step_ff + 4'd1);
   assign rd_rnd  = is_dec ? (nr_ff - rd_step) : rd_step;
   assign rd_en   = (state_ff == ST_FETCH) || (state_ff == ST_ROUND && !last_step);

   always_comb begin
      state_in     = state_ff;
      stale_in     = stale_ff;
      chain_in     = chain_ff;
      blk_in       = blk_ff;
      din_in       = din_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      nr_in        = nr_ff;
      nk_in        = nk_ff;
      wi_in        = wi_ff;
      kc_in        = kc_ff;
      rcon_in      = rcon_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_exp) begin
               nk_in    = 4'd4 + {1'b0, len_sat, 1'b0};
               nr_in    = 4'd10 + {1'b0, len_sat, 1'b0};
               wi_in    = '0;
               kc_in    = '0;
               rcon_in  = 8'h01;
               stale_in = 1'b0;
               state_in = ST_EXPAND;
            end else if (req_xfer) begin
               mode_in = cipher_mode_ff;
               din_in  = {req_tdata[63:0], req_tdata[127:64]};
               step_in = '0;
               if (cipher_mode_ff == MODE_ECB_DEC) begin
                  state_in = ST_DONE;
               end else begin
                  if (cipher_mode_ff != MODE_ECB_ENC && req_tuser) chain_in = '0;
                  blk_in = {req_tdata[63:0], req_tdata[127:64]};
                  if (cipher_mode_ff == MODE_CBC_ENC && !req_tuser) begin
                     blk_in = {req_tdata[63:0], req_tdata[127:64]} ^ chain_ff;
                  end
                  state_in = ST_FETCH;
               end
            end
         end
         ST_EXPAND: begin
            if (key_wr) begin
               state_in = ST_IDLE;
            end else begin
               wi_in = wi_ff + 6'd1;
               kc_in = ({1'b0, kc_ff} == nk_ff - 4'd1) ? 3'd0 : kc_ff + 3'd1;
               if (kc_ff == 3'd0 && wi_ff >= {2'b00, nk_ff}) rcon_in = xtime(rcon_ff);
               if (wi_ff == last_wi) state_in = ST_IDLE;
            end
         end
         ST_FETCH: state_in = ST_ROUND;
         ST_ROUND: begin
            blk_in  = step_out;
            step_in = step_ff + 4'd1;
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (mode_ff == MODE_ECB_DEC) begin
                  rsp_data_in = '0;
                  rsp_err_in  = 1'b1;
               end else begin
                  rsp_data_in = fin;
                  rsp_err_in  = 1'b0;
                  if (mode_ff == MODE_CBC_ENC) chain_in = blk_ff;
                  if (mode_ff == MODE_CBC_DEC) chain_in = din_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (key_wr) stale_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stale_ff       <= 1'b1;
         key_length_ff  <= '0;
         key_word_ff    <= '{default: '0};
         cipher_mode_ff <= MODE_CBC_ENC;
         chain_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
         nr_ff          <= 4'd10;
         nk_ff          <= 4'd4;
         wi_ff          <= '0;
         kc_ff          <= '0;
         rcon_ff        <= 8'h01;
         mode_ff        <= MODE_CBC_ENC;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         nr_ff        <= nr_in;
         nk_ff        <= nk_in;
         wi_ff        <= wi_in;
         kc_ff        <= kc_in;
         rcon_ff      <= rcon_in;
         mode_ff      <= mode_in;
         if (csr_we) begin
            case (csr_addr)
               REG_KEY_LENGTH:  key_length_ff  <= csr_wdata[1:0];
               REG_KEY_WORD_0:  key_word_ff[0] <= csr_wdata;
               REG_KEY_WORD_1:  key_word_ff[1] <= csr_wdata;
               REG_KEY_WORD_2:  key_word_ff[2] <= csr_wdata;
               REG_KEY_WORD_3:  key_word_ff[3] <= csr_wdata;
               REG_CIPHER_MODE: cipher_mode_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      din_ff      <= din_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
      if (shift_win) begin
         win_ff[0] <= new_word;
         for (int i = 1; i < 8; i++) win_ff[i] <= win_ff[i-1];
      end
   end

   // round key memory: each entry holds schedule words 2e (high) and 2e+1 (low)
   always_ff @(posedge clock) begin
      if (mem_we) rk_mem[wi_ff[5:1]] <= {win_ff[0], new_word};
      if (rd_en) begin
         rk_hi_ff <= rk_mem[{rd_rnd, 1'b0}];
         rk_lo_ff <= rk_mem[{rd_rnd, 1'b1}];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[63:0], rsp_data_ff[127:64]};
   assign rsp_tuser  = rsp_err_ff;

   a_ready_fresh: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stale_ff) else $error("input taken with stale round keys");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (step_ff <= nr_ff)) else $error("round step past last round");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0)) else $error("error result with data");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready) else $error("second transfer while block in flight");
   a_expand_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPAND) |-> (wi_ff <= last_wi)) else $error("schedule index overrun");

endmodule

### tb/sv/tb_aes_cbc_ecb_cipher_core.sv
// self-checking testbench for the block cipher core in cbc and ecb modes
`timescale 1ns / 1ps

module tb_aes_cbc_ecb_cipher_core
   import aes_cbc_pkg::*;
;

   typedef struct packed {
      logic [63:0] blk_hi;
      logic [63:0] blk_lo;
      logic        first;
   } block_item_type;

   typedef struct packed {
      logic [63:0] res_hi;
      logic [63:0] res_lo;
      logic        err;
   } cipher_out_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // block_high, block_low
   logic         req_tuser;   // first_block
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // result_high, result_low
   logic         rsp_tuser;   // mode_error
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [63:0]  csr_wdata;

   aes_cbc_ecb_cipher_core dut (.*);

   // predictor state
   logic [1:0]   p_keylen;
   logic [63:0]  p_key [4];
   logic [1:0]   p_mode;
   logic [127:0] p_chain;
   logic [31:0]  p_sched [60];
   int           p_rounds;

   block_item_type  pending_blocks [$];
   cipher_out_type  expected_results [$];
   int           errors;
   int           cycles;
   bit           rsp_quiet;
   bit           req_quiet;
   bit           req_hold;
   bit           req_taken;

   localparam int LIMIT = 2_000_000;

   function automatic logic [7:0] gf_x2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_x2(a);
      end
      return p;
   endfunction

   function automatic logic [7:0] sbox_inverse(input logic [7:0] y);
      for (int i = 0; i < 256; i++)
         if (SBOX[i] == y) return 8'(i);
      return 8'h00;
   endfunction

   function automatic logic [31:0] sub4(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   task automatic build_schedule();
      int nk, total;
      logic [7:0] rc;
      logic [31:0] t;
      nk = (p_keylen == 2'd0) ? 4 : (p_keylen == 2'd1) ? 6 : 8;
      p_rounds = nk + 6;
      total = 4 * (p_rounds + 1);
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         p_sched[i] = i[0] ? p_key[i>>1][31:0] : p_key[i>>1][63:32];
      for (int i = nk; i < total; i++) begin
         t = p_sched[i-1];
         if (i % nk == 0) begin
            t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gf_x2(rc);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub4(t);
         end
         p_sched[i] = p_sched[i-nk] ^ t;
      end
   endtask

   function automatic logic [127:0] add_key(input logic [127:0] s, input int r);
      return s ^ {p_sched[4*r], p_sched[4*r+1], p_sched[4*r+2], p_sched[4*r+3]};
   endfunction

   // byte i of the state sits at bits 127-8i
   function automatic logic [127:0] round_step(input logic [127:0] s, input bit inv,
                                              input bit mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      if (!inv) begin
         for (int i = 0; i < 16; i++) b[i] = SBOX[b[i]];
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[r+4*c] = b[r+4*((c+r)%4)];
      end else begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[r+4*((c+r)%4)] = b[r+4*c];
         for (int i = 0; i < 16; i++) t[i] = sbox_inverse(t[i]);
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
      if (mix && !inv) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            o[127-32*c -: 32] = {gf_mul(a0,2)^gf_mul(a1,3)^a2^a3,
                                 a0^gf_mul(a1,2)^gf_mul(a2,3)^a3,
                                 a0^a1^gf_mul(a2,2)^gf_mul(a3,3),
                                 gf_mul(a0,3)^a1^a2^gf_mul(a3,2)};
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] unmix(input logic [127:0] s);
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         {a0, a1, a2, a3} = s[127-32*c -: 32];
         o[127-32*c -: 32] = {gf_mul(a0,14)^gf_mul(a1,11)^gf_mul(a2,13)^gf_mul(a3,9),
                              gf_mul(a0,9)^gf_mul(a1,14)^gf_mul(a2,11)^gf_mul(a3,13),
                              gf_mul(a0,13)^gf_mul(a1,9)^gf_mul(a2,14)^gf_mul(a3,11),
                              gf_mul(a0,11)^gf_mul(a1,13)^gf_mul(a2,9)^gf_mul(a3,14)};
      end
      return o;
   endfunction

   function automatic logic [127:0] encipher(input logic [127:0] s);
      s = add_key(s, 0);
      for (int r = 1; r < p_rounds; r++) s = add_key(round_step(s, 0, 1), r);
      return add_key(round_step(s, 0, 0), p_rounds);
   endfunction

   function automatic logic [127:0] decipher(input logic [127:0] s);
      s = add_key(s, p_rounds);
      for (int r = p_rounds - 1; r >= 1; r--) s = unmix(add_key(round_step(s, 1, 0), r));
      return add_key(round_step(s, 1, 0), 0);
   endfunction

   function automatic cipher_out_type predict_block(input block_item_type it);
      cipher_out_type o;
      logic [127:0] blk, res;
      blk = {it.blk_hi, it.blk_lo};
      o.err = 1'b0;
      if (p_mode == MODE_ECB_DEC) begin
         o.res_hi = 0; o.res_lo = 0; o.err = 1'b1;
         return o;
      end
      if (p_mode != MODE_ECB_ENC && it.first) p_chain = '0;
      case (p_mode)
         MODE_CBC_ENC: begin
            res = encipher(blk ^ p_chain);
            p_chain = res;
         end
         MODE_CBC_DEC: begin
            res = decipher(blk) ^ p_chain;
            p_chain = blk;
         end
         default: res = encipher(blk);
      endcase
      {o.res_hi, o.res_lo} = res;
      return o;
   endfunction

   // clock and cycle limit
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_blocks.size() > 0 && !req_hold &&
             (req_quiet || $urandom_range(99) >= 20)) begin
            req_tvalid <= 1;
            req_tdata <= {pending_blocks[0].blk_lo, pending_blocks[0].blk_hi};
            req_tuser <= pending_blocks[0].first;
            void'(pending_blocks.pop_front());
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // predict at acceptance
   always @(posedge clock) begin
      block_item_type it;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         it.blk_lo = req_tdata[127:64];
         it.blk_hi = req_tdata[63:0];
         it.first = req_tuser;
         expected_results.push_back(predict_block(it));
      end
   end

   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : (rsp_quiet || $urandom_range(99) >= 20);

   // monitor
   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[63:0] !== want.res_hi) begin
               $error("result_high exp %h got %h", want.res_hi, rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[127:64] !== want.res_lo) begin
               $error("result_low exp %h got %h", want.res_lo, rsp_tdata[127:64]);
               errors++;
            end
            if (rsp_tuser !== want.err) begin
               $error("mode_error exp %b got %b", want.err, rsp_tuser);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         REG_KEY_LENGTH:  p_keylen = val[1:0];
         REG_CIPHER_MODE: p_mode = val[1:0];
         default:         p_key[idx - REG_KEY_WORD_0] = val;
      endcase
      if (idx != REG_CIPHER_MODE) build_schedule();
   endtask

   task automatic drain();
      wait (pending_blocks.size() == 0);
      while (expected_results.size() != 0 || req_tvalid) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_key(input logic [1:0] klen);
      write_reg(REG_KEY_LENGTH, {62'd0, klen});
      write_reg(REG_KEY_WORD_0, rand64());
      write_reg(REG_KEY_WORD_1, rand64());
      write_reg(REG_KEY_WORD_2, rand64());
      write_reg(REG_KEY_WORD_3, rand64());
   endtask

   task automatic queue_random(input int n);
      block_item_type it;
      for (int i = 0; i < n; i++) begin
         it.blk_hi = rand64();
         it.blk_lo = rand64();
         it.first = ($urandom_range(7) == 0);
         pending_blocks.push_back(it);
      end
   endtask

   initial begin
      block_item_type it;
      errors = 0; cycles = 0;
      rsp_quiet = 0; req_quiet = 0; req_hold = 0;
      reset = 1;
      req_tvalid = 0; req_tdata = '0; req_tuser = 0; rsp_tready = 0;
      csr_we = 0; csr_addr = REG_KEY_LENGTH; csr_wdata = '0;
      p_keylen = 0; p_mode = MODE_CBC_ENC; p_chain = '0;
      for (int i = 0; i < 4; i++) p_key[i] = '0;
      build_schedule();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: fips-197 vector, field extremes, every mode and key length
      write_reg(REG_KEY_WORD_0, 64'h0001020304050607);
      write_reg(REG_KEY_WORD_1, 64'h08090a0b0c0d0e0f);
      write_reg(REG_KEY_WORD_2, 64'h1011121314151617);
      write_reg(REG_KEY_WORD_3, 64'h18191a1b1c1d1e1f);
      for (int m = 0; m < 4; m++) begin
         for (int k = 0; k < 4; k++) begin
            write_reg(REG_KEY_LENGTH, 64'(k));
            write_reg(REG_CIPHER_MODE, 64'(m));
            it = '{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1};
            pending_blocks.push_back(it);
            if (k == 0) begin
               pending_blocks.push_back('{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0});
               pending_blocks.push_back('{64'h0, 64'h0, 1'b0});
            end
            drain();
         end
      end
      // chain carries across a switch between the two cbc modes
      write_reg(REG_KEY_LENGTH, 64'd0);
      write_reg(REG_CIPHER_MODE, {62'd0, MODE_CBC_ENC});
      queue_random(2);
      drain();
      write_reg(REG_CIPHER_MODE, {62'd0, MODE_CBC_DEC});
      pending_blocks.push_back('{rand64(), rand64(), 1'b0});
      drain();

      // random phases with all settings
      for (int ph = 0; ph < 12; ph++) begin
         random_key(ph % 4 == 3 ? 2'd3 : 2'(ph % 3));
         write_reg(REG_CIPHER_MODE, (ph % 6 == 5) ? {62'd0, MODE_ECB_DEC}
                                                 : 64'($urandom_range(2)));
         rsp_quiet = (ph == 4); req_quiet = (ph == 4);
         queue_random(95);
         if (ph == 7) begin
            // sender waits until every result is back
            wait (pending_blocks.size() == 40);
            req_hold = 1;
            while (expected_results.size() != 0 || req_tvalid) @(posedge clock);
            req_hold = 0;
         end
         drain();
      end
      rsp_quiet = 0; req_quiet = 0;

      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
